@@ sv/sm4_pkg.sv @@
// Shared types, constants and round functions of the SM4 cipher core.
package sm4_pkg;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned RK_IDX_W = $clog2(ROUNDS);

  // Configuration register indexes.
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  localparam logic [3:0][31:0] FK = '{32'hb27022dc, 32'h677d9197, 32'h56aa3350, 32'ha3b1bac6};

  localparam logic [7:0] SBOX [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
    8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
    8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
    8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95,
    8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
    8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8,
    8'h68, 8'h6B, 8'h81, 8'hB2, 8'h71, 8'h64, 8'hDA, 8'h8B,
    8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2,
    8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
    8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
    8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
    8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
    8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
    8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
    8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
    8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
    8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
    8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
    8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
    8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
  };

  // One pipeline word: four state words plus the direction flag.
  typedef struct packed {
    logic             valid;
    logic             op;
    logic [3:0][31:0] w;
  } cell_word_t;

  function automatic logic [31:0] tau(input logic [31:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic logic [31:0] lin_data(input logic [31:0] t);
    return t ^ {t[29:0], t[31:30]} ^ {t[21:0], t[31:22]} ^ {t[13:0], t[31:14]}
             ^ {t[7:0], t[31:8]};
  endfunction

  function automatic logic [31:0] lin_key(input logic [31:0] t);
    return t ^ {t[18:0], t[31:19]} ^ {t[8:0], t[31:9]};
  endfunction

  // Chain constant i: byte j equals (4i + j) * 7 modulo 256.
  function automatic logic [31:0] ck_word(input logic [RK_IDX_W-1:0] i);
    logic [7:0] base;
    base = {1'b0, i, 2'b00};
    return {8'(base * 8'd7), 8'((base + 8'd1) * 8'd7),
            8'((base + 8'd2) * 8'd7), 8'((base + 8'd3) * 8'd7)};
  endfunction

endpackage

@@ sv/sm4_round_cell.sv @@
// One SM4 round cell: a pipeline register fed by one round of the data path.
module sm4_round_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [31:0]         rk_enc,
  input  logic [31:0]         rk_dec,
  input  sm4_pkg::cell_word_t din,
  output sm4_pkg::cell_word_t dout
);

  logic [31:0] rk;
  logic [31:0] x;
  logic [31:0] f;

  assign rk = din.op ? rk_dec : rk_enc;
  assign x  = din.w[1] ^ din.w[2] ^ din.w[3] ^ rk;
  assign f  = din.w[0] ^ sm4_pkg::lin_data(sm4_pkg::tau(x));

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.op <= din.op;
      // Words slide down one place; the new word enters at the top.
      dout.w  <= {f, din.w[3], din.w[2], din.w[1]};
    end
  end

endmodule

@@ sv/sm4_key_sched.sv @@
// Key registers and iterative round key expansion, one round key per cycle.
module sm4_key_sched (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_wdata,
  output logic        busy,
  output logic [31:0] rk [sm4_pkg::ROUNDS]
);

  logic [63:0]                  key_high;
  logic [63:0]                  key_low;
  logic [63:0]                  key_high_next;
  logic [63:0]                  key_low_next;
  logic [3:0][31:0]             k;
  logic [sm4_pkg::RK_IDX_W-1:0] cnt;
  logic [31:0]                  x;
  logic [31:0]                  k_new;

  always_comb begin
    key_high_next = key_high;
    key_low_next  = key_low;
    unique case (cfg_addr)
      sm4_pkg::REG_KEY_HIGH: key_high_next = cfg_wdata;
      sm4_pkg::REG_KEY_LOW:  key_low_next  = cfg_wdata;
      default:               key_high_next = key_high;
    endcase
  end

  assign x     = k[1] ^ k[2] ^ k[3] ^ sm4_pkg::ck_word(cnt);
  assign k_new = k[0] ^ sm4_pkg::lin_key(sm4_pkg::tau(x));

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      busy     <= 1'b0;
      cnt      <= '0;
    end else if (cfg_wen) begin
      key_high <= key_high_next;
      key_low  <= key_low_next;
      busy     <= 1'b1;
      cnt      <= '0;
    end else if (busy) begin
      cnt  <= cnt + 1'b1;
      busy <= (cnt != sm4_pkg::RK_IDX_W'(sm4_pkg::ROUNDS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_wen) begin
      k <= {key_low_next[31:0], key_low_next[63:32], key_high_next[31:0],
            key_high_next[63:32]} ^ sm4_pkg::FK;
    end else if (busy) begin
      k       <= {k_new, k[3], k[2], k[1]};
      rk[cnt] <= k_new;
    end
  end

  a_write_starts: assert property (@(posedge clk) disable iff (rst)
    cfg_wen |=> busy && cnt == '0)
    else $error("key write did not start expansion");

  a_count_runs: assert property (@(posedge clk) disable iff (rst)
    busy && !cfg_wen && cnt != sm4_pkg::RK_IDX_W'(sm4_pkg::ROUNDS - 1)
      |=> busy && cnt == $past(cnt) + 1'b1)
    else $error("expansion counter did not advance");

  a_ends: assert property (@(posedge clk) disable iff (rst)
    busy && !cfg_wen && cnt == sm4_pkg::RK_IDX_W'(sm4_pkg::ROUNDS - 1) |=> !busy)
    else $error("expansion did not end after the last round key");

endmodule

@@ sv/sm4_block_cipher_core.sv @@
// SM4 block cipher core: key schedule and a chain of 32 round cells.
//
// Channel   Dir  Payload
// s_axis    in   tdata: block_high, block_low; tuser: op (1 = decrypt)
// m_axis    out  tdata: result_high, result_low
// cfg       in   cfg_addr 0 key_high, 1 key_low; cfg_wdata 64 bits
//
// One block enters per cycle while the output is not stalled; its result
// passes the round cells in order, one round per cell, and the chain holds
// one block per cell in flight. A key write starts the expansion (one round
// key per cycle from the shared key round unit); s_axis_tready stays low during it.
// Reset clears the key to zero; round keys are valid only after a key write.
// A stalled output freezes the whole chain; input is taken again as soon
// as the last cell is empty or its word is taken.
module sm4_block_cipher_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // block_high [63:0], block_low [127:64]
  input  logic         s_axis_tuser,   // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // result_high [63:0], result_low [127:64]
  input  logic         cfg_wen,
  input  logic         cfg_addr,
  input  logic [63:0]  cfg_wdata
);

  localparam int unsigned N = sm4_pkg::ROUNDS;

  logic                key_busy;
  logic [31:0]         rk [N];
  logic                advance;
  sm4_pkg::cell_word_t stage [N+1];
  logic [N-1:0]        stage_valid;

  sm4_key_sched u_key_sched (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .busy      (key_busy),
    .rk        (rk)
  );

  assign advance       = !stage[N].valid || m_axis_tready;
  assign s_axis_tready = advance && !key_busy;

  assign stage[0].valid = s_axis_tvalid && s_axis_tready;
  assign stage[0].op    = s_axis_tuser;
  assign stage[0].w     = {s_axis_tdata[95:64], s_axis_tdata[127:96],
                           s_axis_tdata[31:0], s_axis_tdata[63:32]};

  for (genvar r = 0; r < N; r++) begin : g_round
    sm4_round_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (advance),
      .rk_enc (rk[r]),
      .rk_dec (rk[N-1-r]),
      .din    (stage[r]),
      .dout   (stage[r+1])
    );
    assign stage_valid[r] = stage[r+1].valid;
  end

  // Final words leave in reversed order.
  assign m_axis_tvalid = stage[N].valid;
  assign m_axis_tdata  = {stage[N].w[1], stage[N].w[0], stage[N].w[3], stage[N].w[2]};

  a_no_input_in_expansion: assert property (@(posedge clk) disable iff (rst)
    key_busy |-> !s_axis_tready)
    else $error("block accepted during key expansion");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(stage_valid))
    else $error("chain moved while the output was stalled");

  a_no_key_write_in_flight: assert property (@(posedge clk) disable iff (rst)
    $rose(key_busy) |-> $past(cfg_wen))
    else $error("key expansion started without a key write");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the SM4 cipher core: directed table, random blocks, key changes.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;
  localparam int unsigned NUM_ROUNDS = 32;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned BLOCKS_PER_PHASE = 242;
  localparam int unsigned HOLD_CYCLES = 300;

  localparam logic [31:0] FAMILY_KEY [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197,
                                            32'hb27022dc};

  localparam logic [0:255][7:0] SUBST = {
    128'hD690E9FECCE13DB716B614C228FB2C05,
    128'h2B679A762ABE04C3AA44132649860699,
    128'h9C4250F491EF987A33540B43EDCFAC62,
    128'hE4B31CA9C908E89580DF94FA758F3FA6,
    128'h4707A7FCF37317BA83593C19E6854FA8,
    128'h686B81B27164DA8BF8EB0F4B70569D35,
    128'h1E240E5E6358D1A225227C3B01217887,
    128'hD40046579FD327524C3602E7A0C4C89E,
    128'hEABF8AD240C738B5A3F7F2CEF96115A1,
    128'hE0AE5DA49B341A55AD933230F58CB1E3,
    128'h1DF6E22E8266CA60C02923AB0D534E6F,
    128'hD5DB3745DEFD8E2F03FF6A726D6C5B51,
    128'h8D1BAF92BBDDBC7F11D95C411F105AD8,
    128'h0AC13188A5CD7BBD2D74D012B8E5B4B0,
    128'h8969974A0C96777E65B9F109C56EC684,
    128'h18F07DEC3ADC4D2079EE5F3ED7CB3948
  };

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  // One directed row. full_key marks rows that need key_low written as well;
  // typed rows carry the published test vector instead of a prediction.
  typedef struct packed {
    logic        full_key;
    logic        op;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        typed;
    logic [63:0] res_hi;
    logic [63:0] res_lo;
  } stim_row_t;

  localparam logic [63:0] VEC_KEY_HI = 64'h0123456789abcdef;
  localparam logic [63:0] VEC_KEY_LO = 64'hfedcba9876543210;
  localparam logic [63:0] VEC_CT_HI  = 64'h681edf34d206965e;
  localparam logic [63:0] VEC_CT_LO  = 64'h86b3e94f536e4246;
  localparam logic [63:0] ONES       = 64'hffffffffffffffff;
  localparam int unsigned NUM_ROWS = 17;

  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    '{1'b0, OP_ENCRYPT, 64'd0, 64'd0, 1'b0, 64'd0, 64'd0},
    '{1'b0, OP_DECRYPT, 64'd0, 64'd0, 1'b0, 64'd0, 64'd0},
    '{1'b0, OP_ENCRYPT, ONES, ONES, 1'b0, 64'd0, 64'd0},
    '{1'b0, OP_DECRYPT, ONES, ONES, 1'b0, 64'd0, 64'd0},
    '{1'b1, OP_ENCRYPT, VEC_KEY_HI, VEC_KEY_LO, 1'b1, VEC_CT_HI, VEC_CT_LO},
    '{1'b1, OP_DECRYPT, VEC_CT_HI, VEC_CT_LO, 1'b1, VEC_KEY_HI, VEC_KEY_LO},
    '{1'b1, OP_ENCRYPT, 64'd0, 64'd0, 1'b0, 64'd0, 64'd0},
    '{1'b1, OP_DECRYPT, 64'd0, 64'd0, 1'b0, 64'd0, 64'd0},
    '{1'b1, OP_ENCRYPT, ONES, ONES, 1'b0, 64'd0, 64'd0},
    '{1'b1, OP_DECRYPT, ONES, ONES, 1'b0, 64'd0, 64'd0},
    '{1'b1, OP_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 64'd0, 64'd0},
    '{1'b1, OP_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'd0, 64'd0},
    '{1'b1, OP_ENCRYPT, 64'd1, 64'd0, 1'b0, 64'd0, 64'd0},
    '{1'b1, OP_DECRYPT, 64'd0, 64'h8000000000000000, 1'b0, 64'd0, 64'd0},
    '{1'b1, OP_ENCRYPT, 64'h8000000000000000, 64'd1, 1'b0, 64'd0, 64'd0},
    '{1'b1, OP_DECRYPT, 64'h0000000100000000, 64'h0000000080000000, 1'b0, 64'd0, 64'd0},
    '{1'b1, OP_ENCRYPT, VEC_KEY_HI, VEC_KEY_LO, 1'b1, VEC_CT_HI, VEC_CT_LO}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;   // block_high [63:0], block_low [127:64]
  logic         s_axis_tuser = 1'b0; // op
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;        // result_high [63:0], result_low [127:64]
  logic         cfg_wen = 1'b0;
  logic         cfg_addr = 1'b0;
  logic [63:0]  cfg_wdata = '0;

  // Predictor state.
  logic [63:0] key_hi_q = '0;
  logic [63:0] key_lo_q = '0;
  logic [31:0] round_key [NUM_ROUNDS];

  block_t      due_blocks [$];
  int unsigned mismatches = 0;
  logic        no_idle = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;

  sm4_block_cipher_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("[sm4_block_cipher_core] ERROR");
    $finish;
  end

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] subst_word(input logic [31:0] v);
    return {SUBST[v[31:24]], SUBST[v[23:16]], SUBST[v[15:8]], SUBST[v[7:0]]};
  endfunction

  // Byte j of chain constant i is (4i + j) * 7 modulo 256.
  function automatic logic [31:0] chain_word(input int unsigned i);
    logic [31:0] w;
    for (int j = 0; j < 4; j++) w[31 - 8 * j -: 8] = 8'((4 * i + j) * 7);
    return w;
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] k [4];
    logic [31:0] x;
    logic [31:0] t;
    k[0] = key_hi_q[63:32] ^ FAMILY_KEY[0];
    k[1] = key_hi_q[31:0] ^ FAMILY_KEY[1];
    k[2] = key_lo_q[63:32] ^ FAMILY_KEY[2];
    k[3] = key_lo_q[31:0] ^ FAMILY_KEY[3];
    for (int i = 0; i < NUM_ROUNDS; i++) begin
      x = k[(i + 1) % 4] ^ k[(i + 2) % 4] ^ k[(i + 3) % 4] ^ chain_word(i);
      t = subst_word(x);
      k[i % 4] ^= t ^ rotl(t, 13) ^ rotl(t, 23);
      round_key[i] = k[i % 4];
    end
  endfunction

  function automatic block_t sm4_transform(input logic op, input logic [63:0] hi,
                                           input logic [63:0] lo);
    logic [31:0] w [4];
    logic [31:0] x;
    logic [31:0] t;
    int unsigned ki;
    block_t r;
    w[0] = hi[63:32];
    w[1] = hi[31:0];
    w[2] = lo[63:32];
    w[3] = lo[31:0];
    for (int unsigned rd = 0; rd < NUM_ROUNDS; rd++) begin
      ki = (op == OP_DECRYPT) ? NUM_ROUNDS - 1 - rd : rd;
      x = w[(rd + 1) % 4] ^ w[(rd + 2) % 4] ^ w[(rd + 3) % 4] ^ round_key[ki];
      t = subst_word(x);
      w[rd % 4] ^= t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
    end
    r.hi = {w[3], w[2]};
    r.lo = {w[1], w[0]};
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_half();
    case ($urandom_range(9))
      0: return 64'd0;
      1: return ONES;
      2: return 64'd1 << $urandom_range(63);
      default: return rand64();
    endcase
  endfunction

  // Offers one block and records its expected result once it is taken.
  // tvalid is left high so that back-to-back words need no second assignment.
  task automatic offer_block(input logic op, input logic [63:0] hi, input logic [63:0] lo,
                             input logic typed, input block_t typed_res);
    while (!no_idle && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {lo, hi};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    due_blocks.push_back(typed ? typed_res : sm4_transform(op, hi, lo));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (due_blocks.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // The core drops tready while it expands the new key.
  task automatic write_key(input logic idx, input logic [63:0] val);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == sm4_pkg::REG_KEY_HIGH) key_hi_q = val;
    else key_lo_q = val;
    expand_round_keys();
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Output side: random stalls plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    block_t want;
    block_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.hi = m_axis_tdata[63:0];
      got.lo = m_axis_tdata[127:64];
      if (due_blocks.size() == 0) begin
        $display("%0t ns: output word with nothing expected, high %h low %h",
                 $time, got.hi, got.lo);
        mismatches++;
      end else begin
        want = due_blocks.pop_front();
        if (got.hi !== want.hi || got.lo !== want.lo) begin
          $display("%0t ns: expected high %h low %h, got high %h low %h",
                   $time, want.hi, want.lo, got.hi, got.lo);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    block_t    typed_res;
    logic      full_key_set;
    full_key_set = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Only key_high is written first, so key_low keeps its reset value.
    write_key(sm4_pkg::REG_KEY_HIGH, VEC_KEY_HI);
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.full_key && !full_key_set) begin
        wait_drained();
        write_key(sm4_pkg::REG_KEY_LOW, VEC_KEY_LO);
        full_key_set = 1'b1;
      end
      typed_res.hi = row.res_hi;
      typed_res.lo = row.res_lo;
      offer_block(row.op, row.hi, row.lo, row.typed, typed_res);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      no_idle = 1'b0;
      case (p)
        0: begin
          write_key(sm4_pkg::REG_KEY_LOW, rand64());
          write_key(sm4_pkg::REG_KEY_HIGH, rand64());
        end
        1: write_key(sm4_pkg::REG_KEY_HIGH, ONES);
        2: write_key(sm4_pkg::REG_KEY_LOW, ONES);
        3: begin
          write_key(sm4_pkg::REG_KEY_HIGH, 64'd0);
          write_key(sm4_pkg::REG_KEY_LOW, 64'd0);
        end
        4: write_key(sm4_pkg::REG_KEY_LOW, rand64());
        default: begin
          write_key(sm4_pkg::REG_KEY_HIGH, rand64());
          write_key(sm4_pkg::REG_KEY_LOW, rand64());
        end
      endcase
      if (p == 5) no_idle = 1'b1;
      // The output holds off while words keep coming, so the chain fills up.
      if (p == 6) begin
        no_idle = 1'b1;
        hold_req++;
      end
      for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
        if (p == 6 && n == 80) no_idle = 1'b0;
        if (p == 7 && n == BLOCKS_PER_PHASE / 2) wait_drained();
        offer_block(logic'($urandom_range(1)), pick_half(), pick_half(), 1'b0, typed_res);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && due_blocks.size() == 0) begin
      $display("[sm4_block_cipher_core] OK");
    end else begin
      $display("[sm4_block_cipher_core] ERROR");
    end
    $finish;
  end

endmodule
